// ===== rtl/core/q2e_pkg.sv =====
// Shared types, widths and constants for the quaternion to heading/pitch/roll core.
// Holds the arctangent step table used by every CORDIC cell.
// No dependencies.
package q2e_pkg;

   localparam int PROD_W      = 32;   // Q2.14 x Q2.14 product
   localparam int VEC_W       = 34;   // Q28 vector component
   localparam int XW          = 45;   // CORDIC x/y datapath
   localparam int ZW          = 34;   // angle accumulator, 2^-23 degree
   localparam int ANG_W       = 18;   // rounded angle, 1/128 degree
   localparam int ROOT_W      = 29;   // square root result
   localparam int REM_W       = 57;   // square root remainder
   localparam int SQ_W        = 58;   // square of a 29-bit value
   localparam int TRIAL_W     = 59;   // square root trial subtrahend
   localparam int NORM_LIMIT  = 41;   // normalized magnitude lies in [2^40, 2^41)
   localparam int NORM_STEPS  = 6;    // shifts by 32,16,8,4,2,1
   localparam int NORM_MAX_SH = 32;
   localparam int ROUND_SH    = 16;
   localparam int ATAN_EXTRA  = NORM_STEPS + 2;  // pre-rotate + normalize + round
   localparam int VEC_DLY     = ROOT_W + 2;      // square, remainder, root bits

   localparam logic signed [VEC_W-1:0] Q28_ONE      = 34'sd268435456;
   localparam logic signed [ZW-1:0]    DEG180       = 34'sd1509949440;
   localparam logic signed [ZW:0]      ROUND_BIAS   = 35'sd32768;
   localparam logic signed [ANG_W-1:0] HEADING_WRAP = 18'sd46080;
   localparam logic signed [14:0]      PITCH_LIMIT  = 15'sd11520;
   localparam logic [REM_W-1:0]        REM_FULL     = {1'b1, 56'd0};

   typedef struct packed {
      logic signed [PROD_W-1:0] xz;
      logic signed [PROD_W-1:0] wy;
      logic signed [PROD_W-1:0] yz;
      logic signed [PROD_W-1:0] wx;
      logic signed [PROD_W-1:0] xx;
      logic signed [PROD_W-1:0] yy;
   } prod_type;

   typedef struct packed {
      logic up_hi;
      logic up_lo;
   } clamp_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] east;
      logic signed [VEC_W-1:0] north;
      logic signed [VEC_W-1:0] up;
      logic signed [VEC_W-1:0] left_u;
      logic signed [VEC_W-1:0] up_u;
      clamp_type               clamp;
   } vec_type;

   typedef struct packed {
      logic                 zero;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_stage_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_stage_type;

   // atan(2^-i) in 2^-23 degree units
   function automatic logic signed [ZW-1:0] cordic_angle(input logic [4:0] idx);
      logic signed [ZW-1:0] a;
      case (idx)
         5'd0:    a = 34'sd377487360;
         5'd1:    a = 34'sd222843801;
         5'd2:    a = 34'sd117744544;
         5'd3:    a = 34'sd59768969;
         5'd4:    a = 34'sd30000467;
         5'd5:    a = 34'sd15014858;
         5'd6:    a = 34'sd7509261;
         5'd7:    a = 34'sd3754860;
         5'd8:    a = 34'sd1877459;
         5'd9:    a = 34'sd938733;
         5'd10:   a = 34'sd469367;
         5'd11:   a = 34'sd234683;
         5'd12:   a = 34'sd117342;
         5'd13:   a = 34'sd58671;
         5'd14:   a = 34'sd29335;
         5'd15:   a = 34'sd14668;
         5'd16:   a = 34'sd7334;
         5'd17:   a = 34'sd3667;
         5'd18:   a = 34'sd1833;
         5'd19:   a = 34'sd917;
         5'd20:   a = 34'sd458;
         5'd21:   a = 34'sd229;
         5'd22:   a = 34'sd115;
         5'd23:   a = 34'sd57;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/core/quaternion_to_euler_angles_core.sv =====
// Quaternion to heading / pitch / roll core: top level.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_atan2 (which uses q2e_cordic_cell).
//
// Usage:
//   req_* carries one orientation quaternion per item (w, x, y, z, signed Q2.14).
//   rsp_* returns heading [0,360), pitch [-90,90] and roll, all in 1/128 degree.
//   An item moves on a rising edge where valid is high and stall is low.
// Throughput: one item per cycle while the pipeline is not held by a stall (see Stall).
// Depth: set by the 29-stage square root for the pitch cosine, followed by the
//   three parallel CORDIC cell chains.
// The heading and roll vectors ride a delay line alongside the square root so
// all three atan2 chains start in the same cycle.
// Stall: the whole pipeline, input side included, holds while a result sits in
//   the output register and rsp_stall is high; req_stall is that condition.
// Reset: synchronous; clears the pipeline valid bits and rsp_valid, so items in
//   flight are dropped. Data registers are not reset.
module quaternion_to_euler_angles_core import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_heading_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle
);

   localparam int CLAMP_DLY  = CORDIC_STAGES + ATAN_EXTRA;
   localparam int PIPE_DEPTH = 2 + VEC_DLY + CLAMP_DLY;

   logic                    adv;
   logic [PIPE_DEPTH-1:0]   vld_ff;
   prod_type                prod_ff;
   prod_type                prod_in;
   vec_type                 vec_ff;
   vec_type                 vec_in;
   vec_type                 dly_ff [VEC_DLY];
   clamp_type               clp_ff [CLAMP_DLY];
   logic signed [ROOT_W-1:0] up_trunc;
   logic signed [SQ_W-1:0]  sq_full;
   logic [REM_W-1:0]        sq_ff;
   logic [REM_W-1:0]        rem_ff;
   sqrt_stage_type          sq_chain [ROOT_W+1];
   vec_type                 vec_al;
   logic signed [ANG_W-1:0] head_angle;
   logic signed [ANG_W-1:0] pitch_angle;
   logic signed [ANG_W-1:0] roll_angle;
   logic signed [ANG_W-1:0] head_wrap;
   logic signed [14:0]      pitch_in;
   clamp_type               clamp_al;

   logic                    rsp_valid_ff;
   logic [15:0]             rsp_heading_angle_ff;
   logic signed [14:0]      rsp_pitch_angle_ff;
   logic signed [15:0]      rsp_roll_angle_ff;

   // single pipeline enable: moves unless a result is held by the receiver
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // quaternion products
   always_comb begin
      prod_in.xz = PROD_W'(req_quat_x) * PROD_W'(req_quat_z);
      prod_in.wy = PROD_W'(req_quat_w) * PROD_W'(req_quat_y);
      prod_in.yz = PROD_W'(req_quat_y) * PROD_W'(req_quat_z);
      prod_in.wx = PROD_W'(req_quat_w) * PROD_W'(req_quat_x);
      prod_in.xx = PROD_W'(req_quat_x) * PROD_W'(req_quat_x);
      prod_in.yy = PROD_W'(req_quat_y) * PROD_W'(req_quat_y);
   end

   // Q28 axis components, plus the pitch clamp decision
   always_comb begin
      vec_in.east   = (VEC_W'(prod_ff.xz) + VEC_W'(prod_ff.wy)) <<< 1;
      vec_in.north  = (VEC_W'(prod_ff.yz) - VEC_W'(prod_ff.wx)) <<< 1;
      vec_in.up     = Q28_ONE - ((VEC_W'(prod_ff.xx) + VEC_W'(prod_ff.yy)) <<< 1);
      vec_in.left_u = (VEC_W'(prod_ff.xz) - VEC_W'(prod_ff.wy)) <<< 1;
      vec_in.up_u   = (VEC_W'(prod_ff.yz) + VEC_W'(prod_ff.wx)) <<< 1;
      vec_in.clamp.up_hi = (vec_in.up >= Q28_ONE);
      vec_in.clamp.up_lo = (vec_in.up <= -Q28_ONE);
   end

   // up^2 only matters when |up| < 1.0, so 29 bits carry it
   always_comb begin
      up_trunc = signed'(vec_ff.up[ROOT_W-1:0]);
      sq_full  = SQ_W'(up_trunc) * SQ_W'(up_trunc);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_in;
         vec_ff    <= vec_in;
         sq_ff     <= REM_W'(unsigned'(sq_full));
         rem_ff    <= REM_FULL - sq_ff;
         dly_ff[0] <= vec_ff;
         for (int k = 1; k < VEC_DLY; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
         clp_ff[0] <= dly_ff[VEC_DLY-1].clamp;
         for (int k = 1; k < CLAMP_DLY; k++) begin
            clp_ff[k] <= clp_ff[k-1];
         end
      end
   end

   // cos(pitch) = sqrt(1 - up^2), one root bit per cell, MSB first
   assign sq_chain[0] = {rem_ff, ROOT_W'(0)};

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      q2e_sqrt_cell #(
         .BIT_IDX(ROOT_W - 1 - j)
      ) u_sqrt (
         .clock      (clock),
         .adv        (adv),
         .prev_stage (sq_chain[j]),
         .next_stage (sq_chain[j+1])
      );
   end

   assign vec_al = dly_ff[VEC_DLY-1];

   q2e_atan2 #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_heading (
      .clock     (clock),
      .adv       (adv),
      .y_in      (vec_al.east),
      .x_in      (vec_al.north),
      .angle_out (head_angle)
   );

   q2e_atan2 #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_pitch (
      .clock     (clock),
      .adv       (adv),
      .y_in      (vec_al.up),
      .x_in      (VEC_W'(sq_chain[ROOT_W].root)),
      .angle_out (pitch_angle)
   );

   q2e_atan2 #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_roll (
      .clock     (clock),
      .adv       (adv),
      .y_in      (vec_al.left_u),
      .x_in      (vec_al.up_u),
      .angle_out (roll_angle)
   );

   // heading wrap into [0,360) and pitch clamp at the poles
   always_comb begin
      clamp_al  = clp_ff[CLAMP_DLY-1];
      head_wrap = head_angle;
      if (head_angle < 0) begin
         head_wrap = head_angle + HEADING_WRAP;
      end else if (head_angle >= HEADING_WRAP) begin
         head_wrap = head_angle - HEADING_WRAP;
      end
      if (clamp_al.up_hi) begin
         pitch_in = PITCH_LIMIT;
      end else if (clamp_al.up_lo) begin
         pitch_in = -PITCH_LIMIT;
      end else begin
         pitch_in = 15'(pitch_angle);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_heading_angle_ff <= 16'(head_wrap);
         rsp_pitch_angle_ff   <= pitch_in;
         rsp_roll_angle_ff    <= 16'(roll_angle);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_angle = rsp_heading_angle_ff;
   assign rsp_pitch_angle   = rsp_pitch_angle_ff;
   assign rsp_roll_angle    = rsp_roll_angle_ff;

   // wrapped heading never reaches 360 degrees
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_angle < 16'(HEADING_WRAP)))
      else $error("heading out of range");

   // a result shows up only out of the last pipeline stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(vld_ff[PIPE_DEPTH-1]))
      else $error("result without a pipeline item");

   // an empty last stage empties the output register when the pipe moves
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (adv && !vld_ff[PIPE_DEPTH-1]) |=> !rsp_valid)
      else $error("output register kept a taken item");

endmodule

// ===== rtl/core/q2e_sqrt_cell.sv =====
// One bit of the pipelined integer square root (restoring, remainder form).
// Depends on q2e_pkg.
module q2e_sqrt_cell import q2e_pkg::*; #(
   parameter int BIT_IDX = 0
) (
   input  logic           clock,
   input  logic           adv,
   input  sqrt_stage_type prev_stage,
   output sqrt_stage_type next_stage
);

   logic [TRIAL_W-1:0] trial;
   sqrt_stage_type     stage_ff;
   sqrt_stage_type     stage_in;

   // (R + 2^b)^2 - R^2 = R*2^(b+1) + 2^(2b)
   always_comb begin
      trial    = (TRIAL_W'(prev_stage.root) << (BIT_IDX + 1)) + (TRIAL_W'(1) << (2 * BIT_IDX));
      stage_in = prev_stage;
      if (TRIAL_W'(prev_stage.rem) >= trial) begin
         stage_in.rem  = prev_stage.rem - REM_W'(trial);
         stage_in.root = prev_stage.root | (ROOT_W'(1) << BIT_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule

// ===== rtl/core/q2e_cordic_cell.sv =====
// One vectoring micro-rotation of the CORDIC chain, registered.
// Depends on q2e_pkg.
module q2e_cordic_cell import q2e_pkg::*; #(
   parameter int STAGE_IDX = 0
) (
   input  logic             clock,
   input  logic             adv,
   input  cordic_stage_type prev_stage,
   output cordic_stage_type next_stage
);

   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;
   cordic_stage_type     stage_ff;
   cordic_stage_type     stage_in;

   always_comb begin
      dx       = prev_stage.x >>> STAGE_IDX;
      dy       = prev_stage.y >>> STAGE_IDX;
      stage_in = prev_stage;
      if (prev_stage.y >= 0) begin
         stage_in.x = prev_stage.x + dy;
         stage_in.y = prev_stage.y - dx;
         stage_in.z = prev_stage.z + cordic_angle(5'(STAGE_IDX));
      end else begin
         stage_in.x = prev_stage.x - dy;
         stage_in.y = prev_stage.y + dx;
         stage_in.z = prev_stage.z - cordic_angle(5'(STAGE_IDX));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule

// ===== rtl/core/q2e_atan2.sv =====
// Pipelined atan2(y, x): half-plane fold, normalizing shifts, CORDIC cell chain, rounding.
// Depends on q2e_pkg and q2e_cordic_cell.
module q2e_atan2 import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [VEC_W-1:0] y_in,
   input  logic signed [VEC_W-1:0] x_in,
   output logic signed [ANG_W-1:0] angle_out
);

   logic signed [XW-1:0] x_ext;
   logic signed [XW-1:0] y_ext;
   logic [XW-1:0]        x_mag;
   logic [XW-1:0]        y_mag;
   logic [XW-1:0]        mag_in;
   cordic_stage_type     pre_in;
   cordic_stage_type     nrm_ff [NORM_STEPS+1];
   logic [XW-1:0]        mag_ff [NORM_STEPS+1];
   cordic_stage_type     chain [CORDIC_STAGES+1];
   logic signed [ZW:0]   round_sum;
   logic signed [ANG_W-1:0] angle_ff;

   // fold the left half-plane onto the right, +-180 degree base angle
   always_comb begin
      x_ext       = XW'(x_in);
      y_ext       = XW'(y_in);
      pre_in.zero = (x_in == 0) && (y_in == 0);
      if (x_in < 0) begin
         pre_in.x = -x_ext;
         pre_in.y = -y_ext;
         pre_in.z = (y_in >= 0) ? DEG180 : -DEG180;
      end else begin
         pre_in.x = x_ext;
         pre_in.y = y_ext;
         pre_in.z = '0;
      end
      x_mag  = unsigned'(pre_in.x);
      y_mag  = (pre_in.y < 0) ? unsigned'(-pre_in.y) : unsigned'(pre_in.y);
      mag_in = (x_mag > y_mag) ? x_mag : y_mag;
   end

   // binary normalize: largest component ends in [2^40, 2^41)
   always_ff @(posedge clock) begin
      if (adv) begin
         nrm_ff[0] <= pre_in;
         mag_ff[0] <= mag_in;
         for (int k = 0; k < NORM_STEPS; k++) begin
            nrm_ff[k+1].zero <= nrm_ff[k].zero;
            nrm_ff[k+1].z    <= nrm_ff[k].z;
            if (mag_ff[k] < (XW'(1) << (NORM_LIMIT - (NORM_MAX_SH >> k)))) begin
               nrm_ff[k+1].x <= nrm_ff[k].x <<< (NORM_MAX_SH >> k);
               nrm_ff[k+1].y <= nrm_ff[k].y <<< (NORM_MAX_SH >> k);
               mag_ff[k+1]   <= mag_ff[k] << (NORM_MAX_SH >> k);
            end else begin
               nrm_ff[k+1].x <= nrm_ff[k].x;
               nrm_ff[k+1].y <= nrm_ff[k].y;
               mag_ff[k+1]   <= mag_ff[k];
            end
         end
      end
   end

   assign chain[0] = nrm_ff[NORM_STEPS];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      q2e_cordic_cell #(
         .STAGE_IDX(i)
      ) u_cell (
         .clock      (clock),
         .adv        (adv),
         .prev_stage (chain[i]),
         .next_stage (chain[i+1])
      );
   end

   // round half up to 1/128 degree; zero vector gives 0
   always_comb begin
      if (chain[CORDIC_STAGES].zero) begin
         round_sum = ROUND_BIAS;
      end else begin
         round_sum = (ZW + 1)'(chain[CORDIC_STAGES].z) + ROUND_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= ANG_W'(round_sum >>> ROUND_SH);
      end
   end

   assign angle_out = angle_ff;

endmodule
